@@ rtl/bsc_pkg.sv @@
`default_nettype none

package bsc_pkg;

    // pipeline depth, request accept to result valid
    localparam int NSTG = 10;

    // coefficient register indexes
    typedef enum logic [2:0] {
        REG_SENS_OFFS    = 3'd0,
        REG_TCS_TCO      = 3'd1,
        REG_TREF_TEMPCO  = 3'd2,
        REG_PRESSURE_BASE = 3'd3,
        REG_SECOND_ORDER = 3'd4,
        REG_ALTITUDE     = 3'd5,
        REG_TEMP_F_OFFS  = 3'd6,
        REG_BARO_OFFS    = 3'd7
    } cfg_reg_t;

    // raw pressure zero point
    localparam logic signed [16:0] D1_ZERO = 17'sd7168;
    // c4 zero point
    localparam logic signed [16:0] C4_ZERO = 17'sd1024;

    // reciprocal of ten for 32-bit unsigned, used with a 35-bit shift
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    // dUT saturation at 8 fraction bits
    localparam int DUT_LIM = 268435456;

    // 250 tenths of a degree at 32 fraction bits
    localparam logic signed [55:0] T10_BASE = 56'sd250 <<< 32;
    // rounding half for 32 fraction bits
    localparam logic signed [59:0] HALF32 = 60'sd1 <<< 31;

    // fahrenheit zero point in hundredths
    localparam logic signed [28:0] F_ZERO = 29'sd3200;

    // pressure saturation in hPa at 16 fraction bits
    localparam int HPA_LIM = 1073741824;

    // ten-thousandths of an inHg per hPa, scaled by 2^20, and the 36-bit rounding half
    localparam logic [28:0] INHG_K = 29'd309644315;
    localparam logic signed [60:0] HALF36 = 61'sd1 <<< 35;

    // output ranges
    localparam int TC_MIN = -10000;
    localparam int TC_MAX = 20000;
    localparam int TF_MIN = -20000;
    localparam int TF_MAX = 40000;
    localparam int PH_MAX = 700000;

endpackage

`default_nettype wire

@@ rtl/baro_sensor_compensation.sv @@
`default_nettype none

// channel  dir  payload                                              handshake
// s_       in   s_raw_temperature, s_raw_pressure                    s_valid / s_ready
// m_       out  m_temp_celsius, m_temp_fahrenheit, m_pressure_inhg   m_valid / m_ready
// cfg_     in   cfg_index, cfg_data                                  cfg_wr_en, no wait
//
// ten register stages; a request passes through them in order and appears on m_ from the last,
// and one request is accepted every cycle while m_ready stays high
// the deepest stage work is one 32x32 multiply or one 64-bit three-input add
// synchronous reset clears the stage valid bits and all coefficient registers
// on a stall full stages hold, empty stages keep filling; s_ready falls only
// when all ten stages hold requests and m_ready is low

module baro_sensor_compensation (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [15:0]        s_raw_temperature,
    input  wire logic [15:0]        s_raw_pressure,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_temp_celsius,
    output logic signed [16:0]      m_temp_fahrenheit,
    output logic [19:0]             m_pressure_inhg,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    // coefficient registers
    logic [31:0]        sens_offs_reg;
    logic [31:0]        tcs_tco_reg;
    logic [31:0]        tref_tempco_reg;
    logic [15:0]        pbase_reg;
    logic [31:0]        second_reg;
    logic [18:0]        alt_reg;
    logic signed [10:0] tfoff_reg;
    logic signed [10:0] boff_reg;

    // coefficient fields
    logic [15:0] c1, c2, c3, c4, c5, c6, c7;
    logic [7:0]  ka, kb;
    logic [3:0]  kc, kd;

    // stage control
    logic [bsc_pkg::NSTG-1:0] vld_reg, vld_next, stage_en;

    // stage 1
    logic signed [16:0] x_s1;
    logic [16:0]        ax_full;
    logic [15:0]        ax;
    logic [63:0]        recip_prod;
    logic signed [16:0] x1_reg, x1_next;
    logic [31:0]        sq1_reg, sq1_next;
    logic [7:0]         z1_reg, z1_next;
    logic signed [16:0] dd1_reg, dd1_next;
    logic [28:0]        q1_reg, q1_next;

    // stage 2
    logic signed [16:0] x2_reg;
    logic [39:0]        sq2_reg, sq2_next;
    logic signed [16:0] dd2_reg;
    logic [28:0]        q2_reg;

    // stage 3
    logic signed [57:0] dut29, dut_sh;
    logic signed [29:0] dut3_reg, dut3_next;
    logic signed [16:0] dd3_reg;
    logic [28:0]        q3_reg;

    // stage 4
    logic signed [16:0] c4m;
    logic signed [46:0] pc6_reg, pc6_next;
    logic signed [46:0] pc3_reg, pc3_next;
    logic signed [46:0] pc4_reg, pc4_next;
    logic signed [53:0] tsh_reg, tsh_next;
    logic signed [16:0] dd4_reg;
    logic [28:0]        q4_reg;

    // stage 5
    logic signed [55:0] t10_reg, t10_next;
    logic signed [47:0] s18_reg, s18_next;
    logic signed [63:0] offs5_reg, offs5_next;
    logic signed [16:0] dd5_reg;
    logic [28:0]        q5_reg;

    // stage 6
    logic signed [59:0] t10x10, t10x18;
    logic signed [27:0] tcr_reg, tcr_next;
    logic signed [27:0] tfr_reg, tfr_next;
    logic signed [40:0] mhi_reg, mhi_next;
    logic signed [41:0] mlo_reg, mlo_next;
    logic signed [63:0] offs6_reg;
    logic [28:0]        q6_reg;

    // stage 7
    logic signed [28:0] tf_sum;
    logic signed [15:0] tc7_reg, tc7_next;
    logic signed [16:0] tf7_reg, tf7_next;
    logic signed [63:0] xp_reg, xp_next;
    logic [28:0]        q7_reg;

    // stage 8
    logic signed [43:0] p16;
    logic signed [31:0] p8_reg, p8_next;
    logic signed [15:0] tc8_reg;
    logic signed [16:0] tf8_reg;

    // stage 9
    logic signed [60:0] prod_reg, prod_next;
    logic signed [20:0] adj_reg, adj_next;
    logic signed [15:0] tc9_reg;
    logic signed [16:0] tf9_reg;

    // stage 10, output
    logic signed [24:0] ph_r;
    logic signed [25:0] ph_sum;
    logic [19:0]        ph_reg, ph_next;
    logic signed [15:0] tc10_reg;
    logic signed [16:0] tf10_reg;

    // coefficient writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_offs_reg   <= '0;
            tcs_tco_reg     <= '0;
            tref_tempco_reg <= '0;
            pbase_reg       <= '0;
            second_reg      <= '0;
            alt_reg         <= '0;
            tfoff_reg       <= '0;
            boff_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bsc_pkg::REG_SENS_OFFS:     sens_offs_reg   <= cfg_data;
                bsc_pkg::REG_TCS_TCO:       tcs_tco_reg     <= cfg_data;
                bsc_pkg::REG_TREF_TEMPCO:   tref_tempco_reg <= cfg_data;
                bsc_pkg::REG_PRESSURE_BASE: pbase_reg       <= cfg_data[15:0];
                bsc_pkg::REG_SECOND_ORDER:  second_reg      <= cfg_data;
                bsc_pkg::REG_ALTITUDE:      alt_reg         <= cfg_data[18:0];
                bsc_pkg::REG_TEMP_F_OFFS:   tfoff_reg       <= $signed(cfg_data[10:0]);
                bsc_pkg::REG_BARO_OFFS:     boff_reg        <= $signed(cfg_data[10:0]);
                default: ;
            endcase
        end
    end

    // coefficient fields, shift counts clamped to 15
    always_comb begin
        c1 = sens_offs_reg[31:16];
        c2 = sens_offs_reg[15:0];
        c3 = tcs_tco_reg[31:16];
        c4 = tcs_tco_reg[15:0];
        c5 = tref_tempco_reg[31:16];
        c6 = tref_tempco_reg[15:0];
        c7 = pbase_reg;
        ka = second_reg[31:24];
        kb = second_reg[23:16];
        kc = (|second_reg[15:12]) ? 4'hF : second_reg[11:8];
        kd = (|second_reg[7:4])   ? 4'hF : second_reg[3:0];
    end

    // stage enables: a stage loads when it is empty or the next one loads
    always_comb begin
        stage_en[bsc_pkg::NSTG-1] = !vld_reg[bsc_pkg::NSTG-1] || m_ready;
        for (int k = bsc_pkg::NSTG - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
        vld_next[0] = stage_en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < bsc_pkg::NSTG; k++) begin
            vld_next[k] = stage_en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_en[0];

    // stage 1: temperature difference, its square, raw pressure offset, c7/10
    always_comb begin
        x_s1     = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, c5});
        ax_full  = x_s1[16] ? 17'(-x_s1) : 17'(x_s1);
        ax       = ax_full[15:0];
        x1_next  = x_s1;
        sq1_next = ax * ax;
        z1_next  = x_s1[16] ? kb : ka;
        dd1_next = $signed({1'b0, s_raw_pressure}) - bsc_pkg::D1_ZERO;
        recip_prod = {c7, 16'd5} * bsc_pkg::RECIP10;
        q1_next  = recip_prod[63:35];
    end

    // stage 2: second-order square times A or B
    always_comb begin
        sq2_next = sq1_reg * z1_reg;
    end

    // stage 3: dUT at 8 fraction bits, saturated
    always_comb begin
        dut29 = (58'(x2_reg) <<< 29) - $signed(58'(sq2_reg) << (4'd15 - kc));
        dut_sh = dut29 >>> 21;
        if (dut_sh > bsc_pkg::DUT_LIM) begin
            dut3_next = 30'(bsc_pkg::DUT_LIM);
        end else if (dut_sh < -bsc_pkg::DUT_LIM) begin
            dut3_next = 30'(-bsc_pkg::DUT_LIM);
        end else begin
            dut3_next = 30'(dut_sh);
        end
    end

    // stage 4: dUT products with c6, c3, c4-1024 and the D shift term
    always_comb begin
        c4m      = $signed({1'b0, c4}) - bsc_pkg::C4_ZERO;
        pc6_next = dut3_reg * $signed({1'b0, c6});
        pc3_next = dut3_reg * $signed({1'b0, c3});
        pc4_next = dut3_reg * c4m;
        tsh_next = 54'(dut3_reg) <<< (5'd24 - {1'b0, kd});
    end

    // stage 5: temperature sum, sensitivity and offset
    always_comb begin
        t10_next   = bsc_pkg::T10_BASE + (56'(pc6_reg) <<< 8) - 56'(tsh_reg);
        s18_next   = $signed({14'd0, c1, 18'd0}) + 48'(pc3_reg);
        offs5_next = $signed({14'd0, c2, 34'd0}) + (64'(pc4_reg) <<< 12);
    end

    // stage 6: scaled and rounded temperatures, split sensitivity product
    always_comb begin
        t10x10   = (60'(t10_reg) <<< 3) + (60'(t10_reg) <<< 1) + bsc_pkg::HALF32;
        t10x18   = (60'(t10_reg) <<< 4) + (60'(t10_reg) <<< 1) + bsc_pkg::HALF32;
        tcr_next = 28'(t10x10 >>> 32);
        tfr_next = 28'(t10x18 >>> 32);
        mhi_next = $signed(s18_reg[47:24]) * dd5_reg;
        mlo_next = $signed({1'b0, s18_reg[23:0]}) * dd5_reg;
    end

    // stage 7: temperature saturation and trim, pressure difference
    always_comb begin
        if (tcr_reg > bsc_pkg::TC_MAX) begin
            tc7_next = 16'(bsc_pkg::TC_MAX);
        end else if (tcr_reg < bsc_pkg::TC_MIN) begin
            tc7_next = 16'(bsc_pkg::TC_MIN);
        end else begin
            tc7_next = 16'(tcr_reg);
        end
        tf_sum = 29'(tfr_reg) + bsc_pkg::F_ZERO
               + (29'(tfoff_reg) <<< 3) + (29'(tfoff_reg) <<< 1);
        if (tf_sum > bsc_pkg::TF_MAX) begin
            tf7_next = 17'(bsc_pkg::TF_MAX);
        end else if (tf_sum < bsc_pkg::TF_MIN) begin
            tf7_next = 17'(bsc_pkg::TF_MIN);
        end else begin
            tf7_next = 17'(tf_sum);
        end
        xp_next = (64'(mhi_reg) <<< 24) + 64'(mlo_reg) - offs6_reg;
    end

    // stage 8: hPa at 16 fraction bits with base offset, saturated
    always_comb begin
        p16 = 44'(xp_reg >>> 21) + $signed({15'd0, q7_reg});
        if (p16 > bsc_pkg::HPA_LIM) begin
            p8_next = 32'(bsc_pkg::HPA_LIM);
        end else if (p16 < -bsc_pkg::HPA_LIM) begin
            p8_next = 32'(-bsc_pkg::HPA_LIM);
        end else begin
            p8_next = 32'(p16);
        end
    end

    // stage 9: hPa to inHg product, altitude plus user trim
    always_comb begin
        prod_next = p8_reg * $signed({1'b0, bsc_pkg::INHG_K});
        adj_next  = $signed({2'b0, alt_reg}) + (21'(boff_reg) <<< 6)
                  + (21'(boff_reg) <<< 5) + (21'(boff_reg) <<< 2);
    end

    // stage 10: round, add trims, saturate
    always_comb begin
        ph_r   = 25'((prod_reg + bsc_pkg::HALF36) >>> 36);
        ph_sum = 26'(ph_r) + 26'(adj_reg);
        if (ph_sum < 0) begin
            ph_next = '0;
        end else if (ph_sum > bsc_pkg::PH_MAX) begin
            ph_next = 20'(bsc_pkg::PH_MAX);
        end else begin
            ph_next = 20'(ph_sum);
        end
    end

    // stage payload registers
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x1_reg  <= x1_next;
            sq1_reg <= sq1_next;
            z1_reg  <= z1_next;
            dd1_reg <= dd1_next;
            q1_reg  <= q1_next;
        end
        if (stage_en[1]) begin
            x2_reg  <= x1_reg;
            sq2_reg <= sq2_next;
            dd2_reg <= dd1_reg;
            q2_reg  <= q1_reg;
        end
        if (stage_en[2]) begin
            dut3_reg <= dut3_next;
            dd3_reg  <= dd2_reg;
            q3_reg   <= q2_reg;
        end
        if (stage_en[3]) begin
            pc6_reg <= pc6_next;
            pc3_reg <= pc3_next;
            pc4_reg <= pc4_next;
            tsh_reg <= tsh_next;
            dd4_reg <= dd3_reg;
            q4_reg  <= q3_reg;
        end
        if (stage_en[4]) begin
            t10_reg   <= t10_next;
            s18_reg   <= s18_next;
            offs5_reg <= offs5_next;
            dd5_reg   <= dd4_reg;
            q5_reg    <= q4_reg;
        end
        if (stage_en[5]) begin
            tcr_reg   <= tcr_next;
            tfr_reg   <= tfr_next;
            mhi_reg   <= mhi_next;
            mlo_reg   <= mlo_next;
            offs6_reg <= offs5_reg;
            q6_reg    <= q5_reg;
        end
        if (stage_en[6]) begin
            tc7_reg <= tc7_next;
            tf7_reg <= tf7_next;
            xp_reg  <= xp_next;
            q7_reg  <= q6_reg;
        end
        if (stage_en[7]) begin
            p8_reg  <= p8_next;
            tc8_reg <= tc7_reg;
            tf8_reg <= tf7_reg;
        end
        if (stage_en[8]) begin
            prod_reg <= prod_next;
            adj_reg  <= adj_next;
            tc9_reg  <= tc8_reg;
            tf9_reg  <= tf8_reg;
        end
        if (stage_en[9]) begin
            ph_reg   <= ph_next;
            tc10_reg <= tc9_reg;
            tf10_reg <= tf9_reg;
        end
    end

    // result port
    assign m_valid           = vld_reg[bsc_pkg::NSTG-1];
    assign m_temp_celsius    = tc10_reg;
    assign m_temp_fahrenheit = tf10_reg;
    assign m_pressure_inhg   = ph_reg;

endmodule

`default_nettype wire

@@ rtl/bsc_checker.sv @@
`default_nettype none

module bsc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_temp_celsius,
    input wire logic signed [16:0] m_temp_fahrenheit,
    input wire logic [19:0]        m_pressure_inhg
);

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty output stage means the whole pipeline can take a request
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("request refused while output stage empty");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temp_celsius)
            && $stable(m_temp_fahrenheit) && $stable(m_pressure_inhg))
        else $error("stalled result changed");

    // temperatures saturate to their ranges
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_temp_celsius >= bsc_pkg::TC_MIN && m_temp_celsius <= bsc_pkg::TC_MAX
            && m_temp_fahrenheit >= bsc_pkg::TF_MIN
            && m_temp_fahrenheit <= bsc_pkg::TF_MAX)
        else $error("temperature out of range");

    // pressure saturates to its range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pressure_inhg <= bsc_pkg::PH_MAX)
        else $error("pressure out of range");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire
